// ===== rtl/core/i2c_master_bit_engine_assert.svh =====
// ---------------------------------------------------------------------------
// i2c master bit engine assertion macros
// shared helpers for concurrent checks, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication
`define I2CBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cbe_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cbe_pkg
// types and constants shared by the i2c master bit engine
// ---------------------------------------------------------------------------
package i2cbe_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'b1;

	localparam int HP_W   = 16;
	localparam int ATO_W  = 8;
	localparam int CFG_W  = 16;

	localparam logic [HP_W-1:0]  HP_RESET  = 16'd100;
	localparam logic [ATO_W-1:0] ATO_RESET = 8'd250;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// queue between front and back
	localparam int QDEPTH = 2;

	// raw op codes on the input word
	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_START    = 3'd1,
		OP_STOP     = 3'd2,
		OP_WRITE    = 3'd3,
		OP_READ     = 3'd4,
		OP_WAIT_ACK = 3'd5,
		OP_SEND_ACK = 3'd6,
		OP_RSVD     = 3'd7
	} op_t;

	// classified command
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ,
		CMD_WAIT_ACK,
		CMD_SEND_ACK
	} cmd_t;

	// line phases of the sequencer
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_A, PH_ST_B, PH_ST_C,
		PH_SP_A, PH_SP_B,
		PH_WR_D, PH_WR_H, PH_WR_L,
		PH_RD_H, PH_RD_L,
		PH_AK_H, PH_AK_L,
		PH_WA_R, PH_WA_H, PH_WA_P, PH_WA_L
	} phase_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} out_word_t;

	// word held in the queue
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic       sda_in;
	} q_word_t;

	typedef struct packed {
		logic [HP_W-1:0]  half_period;
		logic [ATO_W-1:0] ack_timeout;
	} cfg_t;

endpackage

// ===== rtl/core/i2cbe_front.sv =====
// ---------------------------------------------------------------------------
// i2cbe_front
// accepts input words and classifies the op into a command
// ---------------------------------------------------------------------------
module i2cbe_front
	import i2cbe_pkg::*;
(
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	input  logic     q_full,
	output logic     push,
	output q_word_t  push_data
);

	// accept whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// op decode, the reserved code acts like no command
	always_comb begin
		case (op_t'(in_data.op))
			OP_START:    push_data.cmd = CMD_START;
			OP_STOP:     push_data.cmd = CMD_STOP;
			OP_WRITE:    push_data.cmd = CMD_WRITE;
			OP_READ:     push_data.cmd = CMD_READ;
			OP_WAIT_ACK: push_data.cmd = CMD_WAIT_ACK;
			OP_SEND_ACK: push_data.cmd = CMD_SEND_ACK;
			default:     push_data.cmd = CMD_NONE;
		endcase
		push_data.tx_byte   = in_data.tx_byte;
		push_data.ack_level = in_data.ack_level;
		push_data.sda_in    = in_data.sda_in;
	end

endmodule

// ===== rtl/core/i2cbe_queue.sv =====
// ---------------------------------------------------------------------------
// i2cbe_queue
// short fifo between the front and the back
// ---------------------------------------------------------------------------
module i2cbe_queue
	import i2cbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_word_t push_data,
	input  logic    pop,
	output logic    q_valid,
	output q_word_t q_data,
	output logic    q_full
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	q_word_t          mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == CNT_W'(QDEPTH));
	assign q_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/i2cbe_back.sv =====
// ---------------------------------------------------------------------------
// i2cbe_back
// line phase sequencer, one step per word, with the output register
// ---------------------------------------------------------------------------
module i2cbe_back
	import i2cbe_pkg::*;
#(
	parameter int HOLD_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  q_word_t   q_data,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;

	phase_t                phase_q,  phase_n;
	cmd_t                  cmd_q,    cmd_n;
	logic [3:0]            bit_q,    bit_n;
	logic [HOLD_WIDTH-1:0] hold_q,   hold_n, hold_dec;
	logic [7:0]            shift_q,  shift_n;
	logic [ATO_W-1:0]      poll_q,   poll_n;
	logic                  ackh_q,   ackh_n;
	logic                  scl_q,    scl_n;
	logic                  sda_q,    sda_n;
	logic [7:0]            rx_q,     rx_n;
	logic                  tmo_q,    tmo_n;
	logic                  done;
	logic                  do_poll;
	logic                  enter_en;
	phase_t                enter_ph;
	logic [HOLD_WIDTH-1:0] hold_sat, hold_load;
	logic                  out_valid_q;
	out_word_t             out_data_q;

	// phase hold, saturated to the counter and at least one tick
	if (HOLD_WIDTH >= HP_W) begin : g_hold_wide
		assign hold_sat = HOLD_WIDTH'(cfg.half_period);
	end else begin : g_hold_narrow
		assign hold_sat = (cfg.half_period > HP_W'(HOLD_MAX)) ? HOLD_MAX
			: cfg.half_period[HOLD_WIDTH-1:0];
	end
	assign hold_load = (cfg.half_period == '0) ? HOLD_WIDTH'(1) : hold_sat;

	assign hold_dec = (hold_q != '0) ? hold_q - 1'b1 : hold_q;

	// advance when the output slot is free or being emptied
	assign pop = q_valid && (!out_valid_q || !out_stall);

	// sequencer step
	always_comb begin
		phase_n  = phase_q;
		cmd_n    = cmd_q;
		bit_n    = bit_q;
		hold_n   = hold_q;
		shift_n  = shift_q;
		poll_n   = poll_q;
		ackh_n   = ackh_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		rx_n     = rx_q;
		tmo_n    = tmo_q;
		done     = 1'b0;
		do_poll  = 1'b0;
		enter_en = 1'b0;
		enter_ph = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			// command start
			if (q_data.cmd != CMD_NONE) begin
				cmd_n    = q_data.cmd;
				bit_n    = '0;
				poll_n   = '0;
				enter_en = 1'b1;
				case (q_data.cmd)
					CMD_START: enter_ph = PH_ST_A;
					CMD_STOP:  enter_ph = PH_SP_A;
					CMD_WRITE: begin
						shift_n  = q_data.tx_byte;
						enter_ph = PH_WR_D;
					end
					CMD_READ: begin
						shift_n  = '0;
						ackh_n   = q_data.ack_level;
						enter_ph = PH_RD_H;
					end
					CMD_WAIT_ACK: enter_ph = PH_WA_R;
					default: begin
						ackh_n   = q_data.ack_level;
						enter_ph = PH_AK_H;
					end
				endcase
			end
		end else if (phase_q == PH_WA_P) begin
			do_poll = 1'b1;
		end else begin
			// hold countdown, phase end on zero
			hold_n = hold_dec;
			if (hold_dec == '0) begin
				case (phase_q)
					PH_ST_A: begin enter_en = 1'b1; enter_ph = PH_ST_B; end
					PH_ST_B: begin enter_en = 1'b1; enter_ph = PH_ST_C; end
					PH_SP_A: begin enter_en = 1'b1; enter_ph = PH_SP_B; end
					PH_SP_B: begin
						if (cmd_q == CMD_WAIT_ACK) begin
							tmo_n = 1'b1;
						end
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					PH_WR_D: begin enter_en = 1'b1; enter_ph = PH_WR_H; end
					PH_WR_H: begin enter_en = 1'b1; enter_ph = PH_WR_L; end
					PH_WR_L: begin
						bit_n = bit_q + 4'd1;
						if (bit_n >= BITS_PER_BYTE) begin
							phase_n = PH_IDLE;
							done    = 1'b1;
						end else begin
							shift_n  = {shift_q[6:0], 1'b0};
							enter_en = 1'b1;
							enter_ph = PH_WR_D;
						end
					end
					PH_RD_H: begin
						shift_n  = {shift_q[6:0], q_data.sda_in};
						enter_en = 1'b1;
						enter_ph = PH_RD_L;
					end
					PH_RD_L: begin
						bit_n    = bit_q + 4'd1;
						enter_en = 1'b1;
						if (bit_n >= BITS_PER_BYTE) begin
							rx_n     = shift_q;
							enter_ph = PH_AK_H;
						end else begin
							enter_ph = PH_RD_H;
						end
					end
					PH_AK_H: begin enter_en = 1'b1; enter_ph = PH_AK_L; end
					PH_WA_R: begin enter_en = 1'b1; enter_ph = PH_WA_H; end
					PH_WA_H: do_poll = 1'b1;
					default: begin
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
				endcase
			end
		end

		// ack poll while scl is high
		if (do_poll) begin
			phase_n = PH_WA_P;
			if (!q_data.sda_in) begin
				tmo_n    = 1'b0;
				enter_en = 1'b1;
				enter_ph = PH_WA_L;
			end else if (poll_q >= cfg.ack_timeout) begin
				enter_en = 1'b1;
				enter_ph = PH_SP_A;
			end else begin
				poll_n = poll_q + 1'b1;
			end
		end

		// phase entry sets line levels and reloads the hold
		if (enter_en) begin
			phase_n = enter_ph;
			hold_n  = hold_load;
			case (enter_ph)
				PH_ST_A: begin sda_n = 1'b1; scl_n = 1'b1; end
				PH_ST_B: sda_n = 1'b0;
				PH_ST_C: scl_n = 1'b0;
				PH_SP_A: begin sda_n = 1'b0; scl_n = 1'b1; end
				PH_SP_B: sda_n = 1'b1;
				PH_WR_D: sda_n = shift_n[7];
				PH_WR_H: scl_n = 1'b1;
				PH_WR_L: scl_n = 1'b0;
				PH_RD_H: begin sda_n = 1'b1; scl_n = 1'b1; end
				PH_RD_L: scl_n = 1'b0;
				PH_AK_H: begin sda_n = ackh_n; scl_n = 1'b1; end
				PH_AK_L: scl_n = 1'b0;
				PH_WA_R: sda_n = 1'b1;
				PH_WA_H: scl_n = 1'b1;
				PH_WA_L: scl_n = 1'b0;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= CMD_NONE;
			bit_q   <= '0;
			hold_q  <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			ackh_q  <= 1'b1;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rx_q    <= '0;
			tmo_q   <= 1'b0;
		end else if (pop) begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			bit_q   <= bit_n;
			hold_q  <= hold_n;
			shift_q <= shift_n;
			poll_q  <= poll_n;
			ackh_q  <= ackh_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			rx_q    <= rx_n;
			tmo_q   <= tmo_n;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.scl_out     <= scl_n;
			out_data_q.sda_out     <= sda_n;
			out_data_q.busy_res    <= (phase_n != PH_IDLE);
			out_data_q.done_res    <= done;
			out_data_q.rx_byte     <= rx_n;
			out_data_q.ack_missing <= tmo_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/core/i2c_master_bit_engine.sv =====
// ---------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master bit engine: one input word per clock tick while not stalled, one result word each
// ---------------------------------------------------------------------------
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall | in_data   (op, tx_byte, ack_level, sda_in)
// out     | out | out_valid/out_stall | out_data (scl, sda, busy, done, rx, ack_missing)
// cfg     | in  | cfg_we            | cfg_index, cfg_wdata
//
// one word per cycle sustained while neither side stalls; each taken word is held in a queue
// slot, then one sequencer step moves its result into the output register
// the rate is set by the single-step phase sequencer in the back end
// reset clears the queue, the sequencer (bus released) and loads the
// config regs with their defaults
// an output stall holds the result; the two-entry queue then fills and
// in_stall rises, so each side can stall on its own
// ---------------------------------------------------------------------------
module i2c_master_bit_engine
	import i2cbe_pkg::*;
#(
	parameter int HOLD_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	`include "i2c_master_bit_engine_assert.svh"

	cfg_t    cfg_q;
	logic    push;
	q_word_t push_data;
	logic    pop;
	logic    q_valid;
	q_word_t q_data;
	logic    q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HP_RESET;
			cfg_q.ack_timeout <= ATO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata[HP_W-1:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata[ATO_W-1:0];
				default: ;
			endcase
		end
	end

	i2cbe_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	i2cbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_full    (q_full)
	);

	i2cbe_back #(
		.HOLD_WIDTH (HOLD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// checks
	`I2CBE_ASSERT_NOW(a_pop_needs_word, pop, q_valid, "pop from empty queue")
	`I2CBE_ASSERT_NOW(a_full_has_word, in_stall, q_valid, "queue full but empty")
	`I2CBE_ASSERT_NEXT(a_push_lands, push && !pop, q_valid, "pushed word not held")
	`I2CBE_ASSERT_NOW(a_done_not_busy, out_valid && out_data.done_res, !out_data.busy_res, "done while busy")

endmodule

// ===== test/i2c_master_bit_engine_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// self-checking bench for the i2c master bit engine: tick words carrying
// start, stop, write, read, wait-ack and send-ack commands are streamed in
// under random idling on both channels. A cycle-exact model of the line
// sequencer predicts every result word, and the results are compared field
// by field in order.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
	import i2cbe_pkg::*;

	// sequencer state as tracked by the bench
	typedef struct packed {
		phase_t     ph;
		logic [2:0] cmd;
		logic [3:0] bits;
		logic [15:0] hold;
		logic [7:0] shreg;
		logic [7:0] polls;
		logic       ackl;
		logic       scl;
		logic       sda;
		logic [7:0] rx;
		logic       tmo;
		logic       done;
	} eng_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_word_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	in_word_t  tick_q[$];
	out_word_t bus_expect_q[$];

	// line model on the checking side, and a second copy steering stimulus
	eng_t             chk_eng;
	eng_t             gen_eng;
	logic [HP_W-1:0]  chk_hp, gen_hp;
	logic [ATO_W-1:0] chk_ato, gen_ato;

	int snd_idle_pct = 35;
	int rcv_idle_pct = 84;
	int n_fail = 0;
	int words_seen = 0;
	int hold_left = 0;
	bit pressure_done = 1'b0;
	out_word_t want;

	i2c_master_bit_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic eng_t eng_reset();
		eng_t s;
		s = '0;
		s.ph = PH_IDLE;
		s.ackl = 1'b1;
		s.scl = 1'b1;
		s.sda = 1'b1;
		return s;
	endfunction

	// load the hold counter and set the line levels of a new phase
	// a half period of zero still holds for one tick; the 16-bit register
	// can never exceed the default hold counter, so no saturation here
	function automatic void enter_ph(inout eng_t s, input logic [15:0] hp, input phase_t p);
		s.ph = p;
		s.hold = (hp == 16'd0) ? 16'd1 : hp;
		case (p)
			PH_ST_A: begin s.sda = 1'b1; s.scl = 1'b1; end
			PH_ST_B: s.sda = 1'b0;
			PH_ST_C: s.scl = 1'b0;
			PH_SP_A: begin s.sda = 1'b0; s.scl = 1'b1; end
			PH_SP_B: s.sda = 1'b1;
			PH_WR_D: s.sda = s.shreg[7];
			PH_WR_H: s.scl = 1'b1;
			PH_WR_L: s.scl = 1'b0;
			PH_RD_H: begin s.sda = 1'b1; s.scl = 1'b1; end
			PH_RD_L: s.scl = 1'b0;
			PH_AK_H: begin s.sda = s.ackl; s.scl = 1'b1; end
			PH_AK_L: s.scl = 1'b0;
			PH_WA_R: s.sda = 1'b1;
			PH_WA_H: s.scl = 1'b1;
			PH_WA_L: s.scl = 1'b0;
			default: ;
		endcase
	endfunction

	// one ack poll: low ends the wait, too many high polls fall into a stop
	function automatic void poll_sda(inout eng_t s, input logic [15:0] hp,
			input logic [7:0] ato, input logic sda);
		s.ph = PH_WA_P;
		if (!sda) begin
			s.tmo = 1'b0;
			enter_ph(s, hp, PH_WA_L);
		end else if (s.polls >= ato)
			enter_ph(s, hp, PH_SP_A);
		else
			s.polls = s.polls + 8'd1;
	endfunction

	// advance when the current phase has been held long enough
	function automatic void end_ph(inout eng_t s, input logic [15:0] hp,
			input logic [7:0] ato, input logic sda);
		case (s.ph)
			PH_ST_A: enter_ph(s, hp, PH_ST_B);
			PH_ST_B: enter_ph(s, hp, PH_ST_C);
			PH_SP_A: enter_ph(s, hp, PH_SP_B);
			PH_SP_B: begin
				if (s.cmd == OP_WAIT_ACK)
					s.tmo = 1'b1;
				s.ph = PH_IDLE;
				s.done = 1'b1;
			end
			PH_WR_D: enter_ph(s, hp, PH_WR_H);
			PH_WR_H: enter_ph(s, hp, PH_WR_L);
			PH_WR_L: begin
				s.bits = s.bits + 4'd1;
				if (s.bits >= BITS_PER_BYTE) begin
					s.ph = PH_IDLE;
					s.done = 1'b1;
				end else begin
					s.shreg = {s.shreg[6:0], 1'b0};
					enter_ph(s, hp, PH_WR_D);
				end
			end
			PH_RD_H: begin
				s.shreg = {s.shreg[6:0], sda};
				enter_ph(s, hp, PH_RD_L);
			end
			PH_RD_L: begin
				s.bits = s.bits + 4'd1;
				if (s.bits >= BITS_PER_BYTE) begin
					s.rx = s.shreg;
					enter_ph(s, hp, PH_AK_H);
				end else
					enter_ph(s, hp, PH_RD_H);
			end
			PH_AK_H: enter_ph(s, hp, PH_AK_L);
			PH_WA_R: enter_ph(s, hp, PH_WA_H);
			PH_WA_H: poll_sda(s, hp, ato, sda);
			default: begin
				s.ph = PH_IDLE;
				s.done = 1'b1;
			end
		endcase
	endfunction

	// one clock tick of the engine, returns the result word it produces
	function automatic out_word_t bit_engine_tick(inout eng_t s, input logic [15:0] hp,
			input logic [7:0] ato, input in_word_t w);
		out_word_t r;
		s.done = 1'b0;
		if (s.ph == PH_IDLE) begin
			// new commands only when idle; reserved op acts like none
			if (w.op != OP_NONE && w.op != OP_RSVD) begin
				s.cmd = w.op;
				s.bits = 4'd0;
				s.polls = 8'd0;
				case (w.op)
					OP_START: enter_ph(s, hp, PH_ST_A);
					OP_STOP: enter_ph(s, hp, PH_SP_A);
					OP_WRITE: begin
						s.shreg = w.tx_byte;
						enter_ph(s, hp, PH_WR_D);
					end
					OP_READ: begin
						s.shreg = 8'd0;
						s.ackl = w.ack_level;
						enter_ph(s, hp, PH_RD_H);
					end
					OP_WAIT_ACK: enter_ph(s, hp, PH_WA_R);
					default: begin
						s.ackl = w.ack_level;
						enter_ph(s, hp, PH_AK_H);
					end
				endcase
			end
		end else if (s.ph == PH_WA_P)
			poll_sda(s, hp, ato, w.sda_in);
		else begin
			if (s.hold != 16'd0)
				s.hold = s.hold - 16'd1;
			if (s.hold == 16'd0)
				end_ph(s, hp, ato, w.sda_in);
		end
		r.scl_out = s.scl;
		r.sda_out = s.sda;
		r.busy_res = (s.ph != PH_IDLE);
		r.done_res = s.done;
		r.rx_byte = s.rx;
		r.ack_missing = s.tmo;
		return r;
	endfunction

	// queue a tick word and track the engine on the stimulus side
	task automatic push_tick(input in_word_t w);
		tick_q.push_back(w);
		void'(bit_engine_tick(gen_eng, gen_hp, gen_ato, w));
	endtask

	// tick with no new command; random ops while busy are ignored noise
	task automatic filler(input int low_pct);
		in_word_t w;
		if (gen_eng.ph != PH_IDLE)
			w.op = 3'($urandom_range(7));
		else
			w.op = $urandom_range(1) ? OP_NONE : OP_RSVD;
		w.tx_byte = 8'($urandom);
		w.ack_level = 1'($urandom);
		w.sda_in = ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
		push_tick(w);
	endtask

	// wait for idle, issue one command, optionally run it to completion
	task automatic issue(input op_t op, input logic [7:0] txb, input logic ackl,
			input int low_pct, input bit run_out);
		in_word_t w;
		while (gen_eng.ph != PH_IDLE)
			filler(low_pct);
		repeat ($urandom_range(2))
			filler(low_pct);
		w.op = op;
		w.tx_byte = txb;
		w.ack_level = ackl;
		w.sda_in = 1'($urandom);
		push_tick(w);
		if (run_out)
			while (gen_eng.ph != PH_IDLE)
				filler(low_pct);
	endtask

	// wait-ack: mostly acked after a few high polls, sometimes never
	task automatic ack_wait();
		issue(OP_WAIT_ACK, 8'($urandom), 1'($urandom),
			($urandom_range(7) == 0) ? 0 : 30, 1'b1);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || in_valid || bus_expect_q.size() != 0);
	endtask

	// both registers written while nothing is in flight
	task automatic set_cfg(input logic [HP_W-1:0] hp, input logic [ATO_W-1:0] ato);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_HALF_PERIOD;
		cfg_wdata <= hp;
		@(posedge clk);
		cfg_index <= REG_ACK_TIMEOUT;
		cfg_wdata <= {{(CFG_W-ATO_W){1'b0}}, ato};
		@(posedge clk);
		cfg_we <= 1'b0;
		chk_hp = hp;
		chk_ato = ato;
		gen_hp = hp;
		gen_ato = ato;
		@(negedge clk);
	endtask

	// sender: offer queued words, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				bus_expect_q.push_back(bit_engine_tick(chk_eng, chk_hp, chk_ato, in_data));
			if (!in_valid || !in_stall) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= tick_q.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each accepted result word, random stalls, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (bus_expect_q.size() == 0) begin
					$error("result word with nothing expected");
					n_fail++;
				end else begin
					want = bus_expect_q.pop_front();
					if (out_data.scl_out !== want.scl_out) begin
						$error("scl_out: expected %0d, got %0d", want.scl_out, out_data.scl_out);
						n_fail++;
					end
					if (out_data.sda_out !== want.sda_out) begin
						$error("sda_out: expected %0d, got %0d", want.sda_out, out_data.sda_out);
						n_fail++;
					end
					if (out_data.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, got %0d", want.busy_res,
							out_data.busy_res);
						n_fail++;
					end
					if (out_data.done_res !== want.done_res) begin
						$error("done_res: expected %0d, got %0d", want.done_res,
							out_data.done_res);
						n_fail++;
					end
					if (out_data.rx_byte !== want.rx_byte) begin
						$error("rx_byte: expected %0h, got %0h", want.rx_byte, out_data.rx_byte);
						n_fail++;
					end
					if (out_data.ack_missing !== want.ack_missing) begin
						$error("ack_missing: expected %0d, got %0d", want.ack_missing,
							out_data.ack_missing);
						n_fail++;
					end
				end
			end
			if (hold_left == 0 && words_seen >= 250 && !pressure_done) begin
				hold_left = 120;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// stimulus and phase sequencing
	initial begin
		logic [HP_W-1:0]  rnd_hp[3];
		logic [ATO_W-1:0] rnd_ato[3];
		int               n_gen;
		int               n_rd;
		logic             rd_dir;
		rnd_hp = '{16'd2, 16'd1, 16'd3};
		rnd_ato = '{8'd5, 8'd255, 8'd1};
		chk_eng = eng_reset();
		gen_eng = eng_reset();
		chk_hp = HP_RESET;
		gen_hp = HP_RESET;
		chk_ato = ATO_RESET;
		gen_ato = ATO_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: a start at the default half period, left running
		issue(OP_START, 8'h00, 1'b0, 50, 1'b0);
		repeat (12)
			filler(50);

		// directed: byte extremes, ack and timeout, read ack and nack
		set_cfg(16'd1, 8'd3);
		issue(OP_WRITE, 8'hFF, 1'b0, 50, 1'b1);
		issue(OP_WRITE, 8'h00, 1'b1, 50, 1'b1);
		issue(OP_WAIT_ACK, 8'h5A, 1'b0, 25, 1'b1);
		issue(OP_WAIT_ACK, 8'hA5, 1'b1, 0, 1'b1);
		issue(OP_READ, 8'h3C, 1'b0, 50, 1'b1);
		issue(OP_READ, 8'hC3, 1'b1, 50, 1'b1);
		issue(OP_SEND_ACK, 8'h00, 1'b0, 50, 1'b1);
		issue(OP_SEND_ACK, 8'hFF, 1'b1, 50, 1'b1);
		issue(OP_STOP, 8'h00, 1'b0, 50, 1'b1);
		issue(OP_START, 8'h00, 1'b0, 50, 1'b1);

		// zero half period and zero ack timeout
		set_cfg(16'd0, 8'd0);
		issue(OP_WRITE, 8'($urandom), 1'b0, 50, 1'b1);
		issue(OP_WAIT_ACK, 8'h00, 1'b0, 0, 1'b1);
		issue(OP_WAIT_ACK, 8'h00, 1'b0, 100, 1'b1);
		issue(OP_STOP, 8'h00, 1'b0, 50, 1'b1);

		// random transfers, one idling pattern per setting
		for (int p = 0; p < 3; p++) begin
			set_cfg(rnd_hp[p], rnd_ato[p]);
			snd_idle_pct = (p == 0) ? 35 : (p == 1) ? 84 : 0;
			rcv_idle_pct = (p == 0) ? 84 : (p == 1) ? 35 : 0;
			n_gen = tick_q.size();
			while (tick_q.size() - n_gen < 260) begin
				if ($urandom_range(99) < 15) begin
					// broken sequences: arbitrary commands with random fields
					repeat ($urandom_range(1, 3))
						issue(op_t'($urandom_range(1, 6)), 8'($urandom), 1'($urandom),
							$urandom_range(100), 1'b1);
				end else begin
					// start, address, ack, then reads or writes, stop or restart
					rd_dir = 1'($urandom);
					issue(OP_START, 8'($urandom), 1'($urandom), 50, 1'b1);
					issue(OP_WRITE, {7'($urandom), rd_dir}, 1'($urandom), 50, 1'b1);
					ack_wait();
					n_rd = $urandom_range(1, 3);
					for (int k = 0; k < n_rd; k++) begin
						if (rd_dir)
							issue(OP_READ, 8'($urandom), (k == n_rd - 1), 50, 1'b1);
						else begin
							issue(OP_WRITE, 8'($urandom), 1'($urandom), 50, 1'b1);
							ack_wait();
						end
					end
					if ($urandom_range(3) != 0)
						issue(OP_STOP, 8'($urandom), 1'($urandom), 50, 1'b1);
				end
			end
		end

		// register maxima: a start that stays held for the whole stretch
		set_cfg(16'hFFFF, 8'hFF);
		issue(OP_START, 8'hFF, 1'b1, 50, 1'b0);
		repeat (30)
			filler(50);

		drain();
		repeat (4) @(posedge clk);
		if (n_fail == 0 && bus_expect_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
